/* rtl/pfz_pkg.sv */
// Package for the prime factorizer: widths, sequencer states and the
// result and divider structs, imported by all modules. No dependencies.
`default_nettype none

package pfz_pkg;

  localparam int VALUE_BITS   = 31;
  localparam int EXP_BITS     = 5;
  localparam int CNT_BITS     = 4;
  localparam int MAX_RESULTS  = 9;
  localparam int DIV_CNT_BITS = $clog2(VALUE_BITS + 1);
  localparam int IN_TDATA_W   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((VALUE_BITS + EXP_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_W  = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] factor;
    logic [EXP_BITS-1:0]   exponent;
    logic                  last;
    logic                  is_prime;
    logic                  invalid;
  } result_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [VALUE_BITS-1:0] remainder;
  } div_resp_t;

endpackage

`default_nettype wire

/* rtl/prime_factorizer_core.sv */
// Top level of the trial-division prime factorizer: stream ports and the
// output register. Depends on pfz_pkg and pfz_ctrl.
//
//   channel  | direction | tdata                        | tlast | tuser
//   s_*      | in        | number[30:0]                 | -     | -
//   m_*      | out       | factor[30:0], exponent[35:31]| last  | is_prime[0], invalid[1]
//
// Each trial divisor costs one serial division in the bit-serial divider;
// a number n takes about (sqrt(n) + number of prime factors with
// multiplicity) such divisions.
// One number is worked at a time; the next is taken once the last result
// of the current one has moved into the output register.
// Synchronous active-high reset; a stalled output holds the sequencer.
`default_nettype none

module prime_factorizer_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [pfz_pkg::IN_TDATA_W-1:0]   s_tdata,   // number
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [pfz_pkg::OUT_TDATA_W-1:0]       m_tdata,   // factor, exponent
  output logic                                  m_tlast,
  output logic [pfz_pkg::OUT_TUSER_W-1:0]       m_tuser    // is_prime, invalid
);
  import pfz_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_reg;

  pfz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_number (s_tdata[VALUE_BITS-1:0]),
    .in_ready  (s_tready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_reg <= res;
    end
  end

  assign m_tdata = OUT_TDATA_W'({out_reg.exponent, out_reg.factor});
  assign m_tlast = out_reg.last;
  assign m_tuser = {out_reg.invalid, out_reg.is_prime};

endmodule

`default_nettype wire

/* rtl/pfz_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on pfz_pkg.
`default_nettype none

module pfz_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pfz_pkg::VALUE_BITS-1:0] dividend,
  input  wire logic [pfz_pkg::VALUE_BITS-1:0] divisor,
  output pfz_pkg::div_resp_t                  resp
);
  import pfz_pkg::*;

  logic [VALUE_BITS-1:0]   part_rem;
  logic [VALUE_BITS-1:0]   quot;
  logic [VALUE_BITS-1:0]   dvs;
  logic [DIV_CNT_BITS-1:0] count;
  logic                    busy;
  logic                    done;
  logic [VALUE_BITS:0]     trial;
  logic                    fits;

  assign trial = {part_rem, quot[VALUE_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == DIV_CNT_BITS'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (count == DIV_CNT_BITS'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part_rem <= '0;
      quot     <= dividend;
      dvs      <= divisor;
      count    <= DIV_CNT_BITS'(VALUE_BITS);
    end else if (busy) begin
      if (fits) begin
        part_rem <= VALUE_BITS'(trial - {1'b0, dvs});
      end else begin
        part_rem <= trial[VALUE_BITS-1:0];
      end
      quot  <= {quot[VALUE_BITS-2:0], fits};
      count <= count - DIV_CNT_BITS'(1);
    end
  end

  assign resp.done      = done;
  assign resp.quotient  = quot;
  assign resp.remainder = part_rem;

endmodule

`default_nettype wire

/* rtl/pfz_ctrl.sv */
// Trial-division sequencer: walks the divisors, drives the serial divider
// and forms each (factor, exponent) result. Depends on pfz_pkg, pfz_divider.
`default_nettype none

module pfz_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [pfz_pkg::VALUE_BITS-1:0] in_number,
  output logic                                in_ready,
  output logic                                res_valid,
  input  wire logic                          res_ready,
  output pfz_pkg::result_t                    res
);
  import pfz_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [VALUE_BITS-1:0] remaining;
  logic [VALUE_BITS-1:0] trial_divisor;
  logic [EXP_BITS-1:0]   repeat_count;
  logic [CNT_BITS-1:0]   factor_count;
  result_t               pend;
  logic                  div_start;
  div_resp_t             div;
  logic                  is_root;
  logic                  emit_last;

  pfz_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (remaining),
    .divisor  (trial_divisor),
    .resp     (div)
  );

  assign is_root   = (repeat_count == '0) && (trial_divisor > div.quotient);
  assign emit_last = (remaining == VALUE_BITS'(1)) ||
                     (factor_count == CNT_BITS'(MAX_RESULTS - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_number < VALUE_BITS'(2)) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div.done) begin
          if (is_root || (div.remainder != '0 && repeat_count != '0)) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_START;
          end
        end
      end
      ST_EMIT: begin
        if (res_ready) begin
          state_next = pend.last ? ST_IDLE : ST_START;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    div_start = (state == ST_START);
    res_valid = (state == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining     <= '0;
      trial_divisor <= VALUE_BITS'(2);
      repeat_count  <= '0;
      factor_count  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            remaining     <= in_number;
            trial_divisor <= VALUE_BITS'(2);
            repeat_count  <= '0;
            factor_count  <= '0;
            pend.factor   <= '0;
            pend.exponent <= '0;
            pend.last     <= 1'b1;
            pend.is_prime <= 1'b0;
            pend.invalid  <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div.done) begin
            if (is_root) begin
              pend.factor   <= remaining;
              pend.exponent <= EXP_BITS'(1);
              pend.last     <= 1'b1;
              pend.is_prime <= (factor_count == '0);
              pend.invalid  <= 1'b0;
              factor_count  <= factor_count + CNT_BITS'(1);
              trial_divisor <= remaining;
              remaining     <= VALUE_BITS'(1);
            end else if (div.remainder == '0) begin
              remaining <= div.quotient;
              if (repeat_count != '1) begin
                repeat_count <= repeat_count + EXP_BITS'(1);
              end
            end else begin
              if (repeat_count != '0) begin
                pend.factor   <= trial_divisor;
                pend.exponent <= repeat_count;
                pend.last     <= emit_last;
                pend.is_prime <= emit_last && (factor_count == '0) &&
                                 (repeat_count == EXP_BITS'(1));
                pend.invalid  <= 1'b0;
                factor_count  <= factor_count + CNT_BITS'(1);
              end
              if (remaining != VALUE_BITS'(1)) begin
                trial_divisor <= trial_divisor + VALUE_BITS'(1);
              end
              repeat_count <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res = pend;

endmodule

`default_nettype wire
